### rtl/cmfs_pkg.sv
// Package with shared constants, face codes and types of the cube map face selector.
package cmfs_pkg;

  // Default widths of the direction components and of the coordinate fraction.
  localparam int COMP_WIDTH_DEF      = 16;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // Fixed widths of the result fields.
  localparam int FACE_WIDTH  = 3;
  localparam int COORD_WIDTH = 16;

  // Quotient bits resolved by each full divider stage; the last stage may resolve fewer.
  localparam int DIV_STEPS_PER_STAGE = 2;

  // Face codes.
  localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd5;

  // Side information that travels with a word through the divider.
  typedef struct packed {
    logic [FACE_WIDTH-1:0] face;
    logic                  zero;
  } cmfs_side_t;

endpackage

### rtl/cmfs_if.sv
// Handshake interfaces for the direction words and the face result words.
interface cmfs_dir_if
  import cmfs_pkg::*;
#(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] dir_x;
  logic signed [COMP_WIDTH-1:0] dir_y;
  logic signed [COMP_WIDTH-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfs_face_if
  import cmfs_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [FACE_WIDTH-1:0]  face;
  logic [COORD_WIDTH-1:0] coord_u;
  logic [COORD_WIDTH-1:0] coord_v;
  logic                   zero_vector;

  modport source (output valid, output face, output coord_u, output coord_v,
                  output zero_vector, input ready);
  modport sink   (input valid, input face, input coord_u, input coord_v,
                  input zero_vector, output ready);
endinterface

### rtl/cmfs_div_stage.sv
// One stage of the pipelined restoring divider, two lanes sharing one divisor.
module cmfs_div_stage
  import cmfs_pkg::*;
#(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int QUOT_WIDTH = COORD_FRAC_BITS_DEF + 1,
  parameter int STEPS      = DIV_STEPS_PER_STAGE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [COMP_WIDTH:0]   div_i,
  input  logic [COMP_WIDTH:0]   rem_u_i,
  input  logic [COMP_WIDTH:0]   rem_v_i,
  input  logic [QUOT_WIDTH-1:0] acc_u_i,
  input  logic [QUOT_WIDTH-1:0] acc_v_i,
  input  cmfs_side_t            side_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [COMP_WIDTH:0]   div_o,
  output logic [COMP_WIDTH:0]   rem_u_o,
  output logic [COMP_WIDTH:0]   rem_v_o,
  output logic [QUOT_WIDTH-1:0] acc_u_o,
  output logic [QUOT_WIDTH-1:0] acc_v_o,
  output cmfs_side_t            side_o
);

  logic                  valid_q;
  logic [COMP_WIDTH:0]   div_q, rem_u_q, rem_v_q, rem_u_d, rem_v_d;
  logic [QUOT_WIDTH-1:0] acc_u_q, acc_v_q, acc_u_d, acc_v_d;
  cmfs_side_t            side_q;

  // The stage takes a word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;

  // Shift one dividend bit into each remainder and subtract the divisor where it fits.
  // The accumulator shifts dividend bits out at the top and quotient bits in at the bottom.
  always_comb begin
    logic [COMP_WIDTH+1:0] tu;
    logic [COMP_WIDTH+1:0] tv;
    logic [COMP_WIDTH+1:0] dw;
    dw      = {1'b0, div_i};
    rem_u_d = rem_u_i;
    rem_v_d = rem_v_i;
    acc_u_d = acc_u_i;
    acc_v_d = acc_v_i;
    for (int j = 0; j < STEPS; j++) begin
      tu = {rem_u_d, acc_u_d[QUOT_WIDTH-1]};
      tv = {rem_v_d, acc_v_d[QUOT_WIDTH-1]};
      if (tu >= dw) begin
        tu      = tu - dw;
        acc_u_d = {acc_u_d[QUOT_WIDTH-2:0], 1'b1};
      end else begin
        acc_u_d = {acc_u_d[QUOT_WIDTH-2:0], 1'b0};
      end
      if (tv >= dw) begin
        tv      = tv - dw;
        acc_v_d = {acc_v_d[QUOT_WIDTH-2:0], 1'b1};
      end else begin
        acc_v_d = {acc_v_d[QUOT_WIDTH-2:0], 1'b0};
      end
      rem_u_d = tu[COMP_WIDTH:0];
      rem_v_d = tv[COMP_WIDTH:0];
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      div_q   <= div_i;
      rem_u_q <= rem_u_d;
      rem_v_q <= rem_v_d;
      acc_u_q <= acc_u_d;
      acc_v_q <= acc_v_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign acc_u_o = acc_u_q;
  assign acc_v_o = acc_v_q;
  assign side_o  = side_q;

endmodule

### rtl/cube_map_face_select.sv
// Cube map face selector: major axis pick, face index and pipelined face coordinates.
// Each word is registered in stages 1 to 3, in the divider stages and in the output stage.
// Throughput: one word per cycle while the result side is ready; the divider resolves two quotient bits per stage.
// Reset clears every stage valid bit at once; the data registers are not reset.
module cube_map_face_select
  import cmfs_pkg::*;
#(
  parameter int COMP_WIDTH      = COMP_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmfs_dir_if.sink    dir_i,
  cmfs_face_if.source res_o
);

  localparam int CW   = COMP_WIDTH;
  localparam int QW   = COORD_FRAC_BITS + 1;
  localparam int DW   = CW + COORD_FRAC_BITS + 2;
  localparam int NDIV = (QW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
  localparam int LIM  = (COORD_FRAC_BITS >= COORD_WIDTH) ? (2 ** COORD_WIDTH) - 1
                                                         : (2 ** COORD_FRAC_BITS) - 1;
  localparam int HALF = (2 ** (COORD_FRAC_BITS - 1)) % (2 ** COORD_WIDTH);

  // ---------------------------------------------------------------------------
  // Stage 1: magnitudes of the components.
  logic          s1_v_q, s1_rdy, s2_rdy;
  logic [CW-1:0] x_in, y_in, z_in;
  logic [CW-1:0] x_q, y_q, z_q, ax_q, ay_q, az_q;

  assign x_in   = CW'(dir_i.dir_x);
  assign y_in   = CW'(dir_i.dir_y);
  assign z_in   = CW'(dir_i.dir_z);
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign dir_i.ready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= dir_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && dir_i.valid) begin
      x_q  <= x_in;
      y_q  <= y_in;
      z_q  <= z_in;
      ax_q <= x_in[CW-1] ? (~x_in + 1'b1) : x_in;
      ay_q <= y_in[CW-1] ? (~y_in + 1'b1) : y_in;
      az_q <= z_in[CW-1] ? (~z_in + 1'b1) : z_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: major axis, face and the sc/tc pair from the sign table.
  logic               s2_v_q, s3_rdy;
  logic signed [CW:0] xs, ys, zs, sc_d, tc_d, sc_q, tc_q;
  logic [CW-1:0]      ma_d, ma_q;
  cmfs_side_t         side2_d, side2_q;

  assign xs     = $signed({x_q[CW-1], x_q});
  assign ys     = $signed({y_q[CW-1], y_q});
  assign zs     = $signed({z_q[CW-1], z_q});
  assign s2_rdy = !s2_v_q || s3_rdy;

  // Ties go to X, then Y; a nonnegative major component picks the positive face.
  always_comb begin
    side2_d.zero = (ax_q == '0) && (ay_q == '0) && (az_q == '0);
    if ((ax_q >= ay_q) && (ax_q >= az_q)) begin
      ma_d = ax_q;
      tc_d = -ys;
      if (!x_q[CW-1]) begin
        side2_d.face = FACE_POS_X;
        sc_d         = -zs;
      end else begin
        side2_d.face = FACE_NEG_X;
        sc_d         = zs;
      end
    end else if (ay_q >= az_q) begin
      ma_d = ay_q;
      sc_d = xs;
      if (!y_q[CW-1]) begin
        side2_d.face = FACE_POS_Y;
        tc_d         = zs;
      end else begin
        side2_d.face = FACE_NEG_Y;
        tc_d         = -zs;
      end
    end else begin
      ma_d = az_q;
      tc_d = -ys;
      if (!z_q[CW-1]) begin
        side2_d.face = FACE_POS_Z;
        sc_d         = xs;
      end else begin
        side2_d.face = FACE_NEG_Z;
        sc_d         = -xs;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      sc_q    <= sc_d;
      tc_q    <= tc_d;
      ma_q    <= ma_d;
      side2_q <= side2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dividends (sc + ma) * 2^F + ma over the divisor 2 * ma, which
  // rounds the quotient to nearest with ties up.
  logic          s3_v_q;
  logic [CW+1:0] nu_w, nv_w;
  logic [DW-1:0] du, dv;
  logic [CW:0]   div_q3, ru_q3, rv_q3;
  logic [QW-1:0] au_q3, av_q3;
  cmfs_side_t    side3_q;

  assign nu_w = $unsigned({sc_q[CW], sc_q}) + {2'b00, ma_q};
  assign nv_w = $unsigned({tc_q[CW], tc_q}) + {2'b00, ma_q};
  assign du   = (DW'(nu_w[CW:0]) << COORD_FRAC_BITS) + DW'(ma_q);
  assign dv   = (DW'(nv_w[CW:0]) << COORD_FRAC_BITS) + DW'(ma_q);

  logic          dv_vld [NDIV+1];
  logic          dv_rdy [NDIV+1];
  logic [CW:0]   dv_div [NDIV+1];
  logic [CW:0]   dv_ru  [NDIV+1];
  logic [CW:0]   dv_rv  [NDIV+1];
  logic [QW-1:0] dv_au  [NDIV+1];
  logic [QW-1:0] dv_av  [NDIV+1];
  cmfs_side_t    dv_side[NDIV+1];

  assign s3_rdy = !s3_v_q || dv_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  // The quotient stays below 2^QW, so the top part of the dividend is already
  // a valid starting remainder and only the low QW bits are shifted through.
  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      div_q3  <= {ma_q, 1'b0};
      ru_q3   <= du[DW-1:QW];
      rv_q3   <= dv[DW-1:QW];
      au_q3   <= du[QW-1:0];
      av_q3   <= dv[QW-1:0];
      side3_q <= side2_q;
    end
  end

  assign dv_vld[0]  = s3_v_q;
  assign dv_div[0]  = div_q3;
  assign dv_ru[0]   = ru_q3;
  assign dv_rv[0]   = rv_q3;
  assign dv_au[0]   = au_q3;
  assign dv_av[0]   = av_q3;
  assign dv_side[0] = side3_q;

  // ---------------------------------------------------------------------------
  // Divider stages, two quotient bits each (fewer in the last one).
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int STEPS = ((QW - k * DIV_STEPS_PER_STAGE) < DIV_STEPS_PER_STAGE)
                           ? (QW - k * DIV_STEPS_PER_STAGE) : DIV_STEPS_PER_STAGE;
    cmfs_div_stage #(
      .COMP_WIDTH(CW),
      .QUOT_WIDTH(QW),
      .STEPS     (STEPS)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_vld[k]),
      .ready_o(dv_rdy[k]),
      .div_i  (dv_div[k]),
      .rem_u_i(dv_ru[k]),
      .rem_v_i(dv_rv[k]),
      .acc_u_i(dv_au[k]),
      .acc_v_i(dv_av[k]),
      .side_i (dv_side[k]),
      .valid_o(dv_vld[k+1]),
      .ready_i(dv_rdy[k+1]),
      .div_o  (dv_div[k+1]),
      .rem_u_o(dv_ru[k+1]),
      .rem_v_o(dv_rv[k+1]),
      .acc_u_o(dv_au[k+1]),
      .acc_v_o(dv_av[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: saturation and the zero vector case.
  logic                   out_v_q, out_rdy;
  logic [QW-1:0]          qu, qv;
  logic [COORD_WIDTH-1:0] cu_d, cv_d, cu_q, cv_q;
  cmfs_side_t             out_side_q;

  assign qu      = dv_au[NDIV];
  assign qv      = dv_av[NDIV];
  assign out_rdy = !out_v_q || res_o.ready;
  assign dv_rdy[NDIV] = out_rdy;

  always_comb begin
    if (dv_side[NDIV].zero) begin
      cu_d = COORD_WIDTH'(HALF);
      cv_d = COORD_WIDTH'(HALF);
    end else begin
      cu_d = (qu > QW'(LIM)) ? COORD_WIDTH'(LIM) : COORD_WIDTH'(qu);
      cv_d = (qv > QW'(LIM)) ? COORD_WIDTH'(LIM) : COORD_WIDTH'(qv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv_vld[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dv_vld[NDIV]) begin
      cu_q       <= cu_d;
      cv_q       <= cv_d;
      out_side_q <= dv_side[NDIV];
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.face        = out_side_q.face;
  assign res_o.coord_u     = cu_q;
  assign res_o.coord_v     = cv_q;
  assign res_o.zero_vector = out_side_q.zero;

  // ---------------------------------------------------------------------------
  // Assertions.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_i.valid && dir_i.ready) |=> s1_v_q)
    else $error("accepted direction word did not reach the first stage");

  a_zero_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.zero_vector) |-> (res_o.face == FACE_POS_X))
    else $error("zero vector result with a face other than +X");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.face <= FACE_NEG_Z))
    else $error("face code out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_o.ready) |=> (out_v_q && $stable(cu_q) && $stable(cv_q)))
    else $error("stalled result word changed");

endmodule

### tb/tb_cube_map_face_select.sv
`timescale 1ns / 1ps
// Self-checking testbench of the cube map face selector with a handshake driver and monitor.
module tb_cube_map_face_select;
  import cmfs_pkg::*;

  localparam int COMP_W        = COMP_WIDTH_DEF;
  localparam int FRAC          = COORD_FRAC_BITS_DEF;
  localparam longint FRAC_TOP  = (64'd1 << FRAC) - 1;
  localparam longint COORD_TOP = (FRAC_TOP > 65535) ? 65535 : FRAC_TOP;
  localparam int RANDOM_WORDS  = 350;    // per idling phase
  localparam int DRAIN_CYCLES  = 40;     // about three times the pipeline depth
  localparam int CYCLE_LIMIT   = 200000;

  // Direction word as queued for the driver.
  typedef struct packed {
    logic [COMP_W-1:0] x;
    logic [COMP_W-1:0] y;
    logic [COMP_W-1:0] z;
  } dir_word_t;

  // Face result word as predicted and as observed.
  typedef struct packed {
    logic [FACE_WIDTH-1:0]  face;
    logic [COORD_WIDTH-1:0] coord_u;
    logic [COORD_WIDTH-1:0] coord_v;
    logic                   zero_vector;
  } face_word_t;

  logic clk = 1'b0;
  logic rst_n;

  cmfs_dir_if #(.COMP_WIDTH(COMP_W)) dir_if ();
  cmfs_face_if res_if ();

  cube_map_face_select dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .dir_i  (dir_if),
    .res_o  (res_if)
  );

  dir_word_t  pending_dirs[$];
  face_word_t expected_faces[$];
  int         send_idle_pct;
  int         recv_idle_pct;
  int         err_count   = 0;
  int         cycle_count = 0;
  bit         dir_taken   = 1'b0;

  // Clock with a period of 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Face coordinate: round((sc + ma) * 2^(F-1) / ma) to nearest, ties up, saturated.
  function automatic logic [COORD_WIDTH-1:0] face_coord(input longint sc, input longint ma);
    longint q;
    q = (2 * ((sc + ma) << (FRAC - 1)) + ma) / (2 * ma);
    if (q > COORD_TOP) q = COORD_TOP;
    return q[COORD_WIDTH-1:0];
  endfunction

  // Picks the major axis and face, then works out both face coordinates.
  function automatic face_word_t predict_face(input logic signed [COMP_W-1:0] x,
                                              input logic signed [COMP_W-1:0] y,
                                              input logic signed [COMP_W-1:0] z);
    longint vx, vy, vz, ax, ay, az, ma, sc, tc;
    face_word_t r;
    vx = x;
    vy = y;
    vz = z;
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    az = (vz < 0) ? -vz : vz;
    r.zero_vector = 1'b0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.face        = FACE_POS_X;
      r.coord_u     = COORD_WIDTH'(64'd1 << (FRAC - 1));
      r.coord_v     = r.coord_u;
      r.zero_vector = 1'b1;
      return r;
    end
    // Ties favor X over Y over Z; a major component of zero or more is positive.
    if (ax >= ay && ax >= az) begin
      ma = ax;
      tc = -vy;
      if (vx >= 0) begin
        r.face = FACE_POS_X;
        sc = -vz;
      end else begin
        r.face = FACE_NEG_X;
        sc = vz;
      end
    end else if (ay >= az) begin
      ma = ay;
      sc = vx;
      if (vy >= 0) begin
        r.face = FACE_POS_Y;
        tc = vz;
      end else begin
        r.face = FACE_NEG_Y;
        tc = -vz;
      end
    end else begin
      ma = az;
      tc = -vy;
      if (vz >= 0) begin
        r.face = FACE_POS_Z;
        sc = vx;
      end else begin
        r.face = FACE_NEG_Z;
        sc = -vx;
      end
    end
    r.coord_u = face_coord(sc, ma);
    r.coord_v = face_coord(tc, ma);
    return r;
  endfunction

  task automatic queue_dir(input int x, input int y, input int z);
    pending_dirs.push_back('{x[COMP_W-1:0], y[COMP_W-1:0], z[COMP_W-1:0]});
  endtask

  // Driver: holds a word until it is taken, then offers the next one or idles.
  always @(negedge clk) begin
    dir_word_t word;
    if (!rst_n) begin
      dir_if.valid <= 1'b0;
      dir_if.dir_x <= '0;
      dir_if.dir_y <= '0;
      dir_if.dir_z <= '0;
      res_if.ready <= 1'b0;
    end else begin
      if (!dir_if.valid || dir_taken) begin
        if (pending_dirs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          word = pending_dirs.pop_front();
          dir_if.dir_x <= word.x;
          dir_if.dir_y <= word.y;
          dir_if.dir_z <= word.z;
          dir_if.valid <= 1'b1;
        end else begin
          dir_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts each accepted direction word and checks each result word.
  always @(posedge clk) begin
    face_word_t got;
    face_word_t want;
    if (rst_n && dir_if.valid && dir_if.ready) begin
      expected_faces.push_back(predict_face(dir_if.dir_x, dir_if.dir_y, dir_if.dir_z));
    end
    dir_taken = rst_n && dir_if.valid && dir_if.ready;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.face, res_if.coord_u, res_if.coord_v, res_if.zero_vector};
      if (expected_faces.size() == 0) begin
        err_count++;
        $display("%0t: result word with none expected: face %0d u %0d v %0d zero %0b",
                 $time, got.face, got.coord_u, got.coord_v, got.zero_vector);
      end else begin
        want = expected_faces.pop_front();
        if (got !== want) begin
          err_count++;
          $display(
            "%0t: expected face %0d u %0d v %0d zero %0b, got face %0d u %0d v %0d zero %0b",
            $time, want.face, want.coord_u, want.coord_v, want.zero_vector,
            got.face, got.coord_u, got.coord_v, got.zero_vector);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int ph, n, s;
    int corner [5];
    logic signed [COMP_W-1:0] x, y, z;
    corner        = '{-32768, 32767, 0, -1, 1};
    send_idle_pct = 38;
    recv_idle_pct = 62;
    rst_n         = 1'b0;

    // Directed words: zero vector, every face at full scale, ties and saturation.
    queue_dir(0, 0, 0);
    queue_dir(32767, 0, 0);
    queue_dir(-32768, 0, 0);
    queue_dir(0, 32767, 0);
    queue_dir(0, -32768, 0);
    queue_dir(0, 0, 32767);
    queue_dir(0, 0, -32768);
    queue_dir(1, 0, 0);
    queue_dir(-1, 0, 0);
    queue_dir(5, 5, 5);
    queue_dir(-5, 5, -5);
    queue_dir(0, 7, -7);
    queue_dir(0, -7, 7);
    queue_dir(100, -100, 0);
    queue_dir(100, 0, -100);
    queue_dir(-32768, -32768, -32768);
    queue_dir(32767, -32768, 32767);
    queue_dir(-32768, 32767, -32767);
    queue_dir(3, -1, 2);
    queue_dir(-7, 3, -6);
    queue_dir(1, -1, 1);
    queue_dir(12345, -23456, 30000);
    queue_dir(-1, -1, -1);
    queue_dir(0, 0, -1);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Three idling phases: receiver-heavy stalls, sender-heavy gaps, then full rate.
    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 62;
        recv_idle_pct = 38;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < RANDOM_WORDS; n++) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
        case ($urandom_range(9))
          5, 6: begin
            // Two components of equal magnitude, the third shifted right by 0 to 15 bits so they tend to lead.
            s = $urandom_range(15);
            case ($urandom_range(2))
              0: begin
                y = $urandom_range(1) ? x : -x;
                z = z >>> s;
              end
              1: begin
                z = $urandom_range(1) ? y : -y;
                x = x >>> s;
              end
              default: begin
                z = $urandom_range(1) ? x : -x;
                y = y >>> s;
              end
            endcase
          end
          7, 8: begin
            x = corner[$urandom_range(4)];
            y = corner[$urandom_range(4)];
            z = corner[$urandom_range(4)];
          end
          9: begin
            x = $urandom_range(8) - 4;
            y = $urandom_range(8) - 4;
            z = $urandom_range(8) - 4;
          end
          default: ;
        endcase
        pending_dirs.push_back('{x, y, z});
      end
      while (pending_dirs.size() != 0) @(posedge clk);
    end

    // Wait for every expected word, then watch a while for strays.
    while (pending_dirs.size() != 0 || dir_if.valid || expected_faces.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_faces.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cmfs_pkg.sv
rtl/cmfs_if.sv
rtl/cmfs_div_stage.sv
rtl/cube_map_face_select.sv
tb/tb_cube_map_face_select.sv
